>>> sv/gcpb_pkg.sv
// Package for the grid cell point binning block: sizes, item kinds and types.
// No dependencies.
package gcpb_pkg;
   localparam int MAX_SIDE   = 16;
   localparam int COORD_BITS = 20;
   localparam int COUNT_BITS = 16;
   localparam int SIDE_BITS  = $clog2(MAX_SIDE + 1);
   localparam int AXIS_BITS  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int NUM_CELLS  = MAX_SIDE * MAX_SIDE * MAX_SIDE;
   localparam int CELL_BITS  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_COUNT = 2'd0;
   localparam kind_type KIND_CLOSE = 2'd1;
   localparam kind_type KIND_PLACE = 2'd2;
   localparam kind_type KIND_CLEAR = 2'd3;

   localparam logic [0:0] REG_BOX  = 1'b0;
   localparam logic [0:0] REG_SIDE = 1'b1;
endpackage

>>> sv/gcpb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gcpb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> sv/grid_cell_point_binning.sv
// Top level of the grid cell point binning block (cell-list counting sort).
// Depends on gcpb_pkg and gcpb_ram.
//
//  channel | dir | handshake                 | payload
//  req     | in  | req_tvalid / req_tready   | tuser kind, tdata x,y,z
//  rsp     | out | rsp_tvalid / rsp_tready   | tdata cell,slot,packed,total,flags
//  csr     | in  | APB psel/penable/pwrite   | box_length, cells_per_side
//
// For count and place words a bit-serial divider works out each axis cell in
// turn; then the cell address is formed, and the counter is read and, in the
// matching phase, written back. Clear words, and close words outside the place
// phase, walk all NUM_CELLS entries, one per cycle. After reset a clearing pass
// empties both memories while no word is accepted. A finished word waits in the
// output register; the next word is taken only once the output register is free.
module grid_cell_point_binning
   import gcpb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [63:0] req_tdata,   // x_pos[19:0], y_pos[39:20], z_pos[59:40], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // cell_index[11:0], slot[27:12], packed[43:28],
                                    // total[59:44], out_of_range[60], overflow[61]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   typedef enum logic [2:0] {
      ST_WIPE, ST_IDLE, ST_DIV, ST_READ, ST_MODIFY, ST_SWEEP, ST_DONE
   } state_type;

   localparam int PROD_BITS = COORD_BITS + SIDE_BITS;

   state_type                state_ff, state_in;
   logic [COORD_BITS-1:0]    box_ff;
   logic [4:0]               side_cfg_ff;
   logic [SIDE_BITS-1:0]     side_ff;        // effective side latched per word
   kind_type                 kind_ff;
   logic [COORD_BITS-1:0]    pos_ff [3];
   logic [1:0]               axis_ff;
   logic [PROD_BITS-1:0]     rem_ff;
   logic [PROD_BITS-1:0]     num_ff;
   logic [AXIS_BITS-1:0]     quo_ff;
   logic [$clog2(PROD_BITS+1)-1:0] bit_ff;
   logic [AXIS_BITS-1:0]     ax_cell_ff [3];
   logic                     oor_ff;
   logic [CELL_BITS-1:0]     cell_ff;
   logic [CELL_BITS:0]       sweep_ff;
   logic [COUNT_BITS-1:0]    run_ff;
   logic [COUNT_BITS-1:0]    total_ff;
   logic                     placing_ff;
   logic [63:0]              rsp_data_ff;
   logic                     rsp_valid_ff;

   // memory ports
   logic                     cnt_we, st_we;
   logic [CELL_BITS-1:0]     cnt_wa, rd_addr, st_wa;
   logic [COUNT_BITS-1:0]    cnt_wd, st_wd, cnt_rd, st_rd;

   logic [SIDE_BITS-1:0]     side_eff;
   logic [PROD_BITS-1:0]     trial;
   logic [PROD_BITS-1:0]     box_ext;
   logic [COORD_BITS-1:0]    cur_pos;
   logic [CELL_BITS-1:0]     lin_cell;
   logic                     csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_SIDE) ? {27'd0, side_cfg_ff}
                                                  : {{(32-COORD_BITS){1'b0}}, box_ff};

   always_comb begin
      if (side_cfg_ff == 5'd0) side_eff = SIDE_BITS'(1);
      else if (int'(side_cfg_ff) > MAX_SIDE) side_eff = SIDE_BITS'(MAX_SIDE);
      else side_eff = SIDE_BITS'(side_cfg_ff);
   end

   assign box_ext = PROD_BITS'(box_ff);
   assign cur_pos = pos_ff[axis_ff];
   // restoring division step: shift in the next numerator bit
   assign trial   = {rem_ff[PROD_BITS-2:0], num_ff[PROD_BITS-1]};
   // x + side*(y + side*z): small multiplies by at most MAX_SIDE
   assign lin_cell = CELL_BITS'(ax_cell_ff[0])
                   + CELL_BITS'(side_ff) * (CELL_BITS'(ax_cell_ff[1])
                   + CELL_BITS'(side_ff) * CELL_BITS'(ax_cell_ff[2]));

   gcpb_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_CELLS)) u_counts (
      .clock, .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
      .rd_addr(rd_addr), .rd_data(cnt_rd));
   gcpb_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_CELLS)) u_starts (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(rd_addr), .rd_data(st_rd));

   logic [CELL_BITS-1:0] sweep_prev;   // cell whose read data arrives now
   assign sweep_prev = CELL_BITS'(sweep_ff - 1'b1);

   always_comb begin
      cnt_we = 1'b0; st_we = 1'b0;
      cnt_wa = cell_ff; st_wa = cell_ff;
      cnt_wd = '0; st_wd = '0;
      rd_addr = cell_ff;
      state_in = state_ff;
      if (state_ff == ST_SWEEP) begin
         rd_addr = sweep_ff[CELL_BITS-1:0];
      end
      case (state_ff)
         ST_WIPE: begin
            cnt_we = 1'b1; st_we = 1'b1;
            cnt_wa = sweep_ff[CELL_BITS-1:0]; st_wa = sweep_ff[CELL_BITS-1:0];
         end
         ST_SWEEP: begin
            if (sweep_ff != '0) begin
               cnt_we = 1'b1;
               cnt_wa = sweep_prev;
               st_we  = 1'b1;
               st_wa  = sweep_prev;
               st_wd  = (kind_ff == KIND_CLOSE) ? run_ff : '0;
            end
         end
         ST_MODIFY: begin
            // The counter is written back only once its read data is valid.
            if (bit_ff != '0) begin
               if (kind_ff == KIND_COUNT && !placing_ff) begin
                  cnt_we = 1'b1;
                  cnt_wd = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
               end else if (kind_ff == KIND_PLACE && placing_ff) begin
                  cnt_we = 1'b1;
                  cnt_wd = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      logic [COUNT_BITS:0] sum;
      logic                ovf;
      logic [63:0]         word;
      if (reset) begin
         state_ff     <= ST_WIPE;
         sweep_ff     <= '0;
         box_ff       <= COORD_BITS'(1048575);
         side_cfg_ff  <= 5'd16;
         total_ff     <= '0;
         placing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            if (csr_paddr[2] == REG_BOX) box_ff <= csr_pwdata[COORD_BITS-1:0];
            else side_cfg_ff <= csr_pwdata[4:0];
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_WIPE: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == (CELL_BITS+1)'(NUM_CELLS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  kind_ff   <= req_tuser;
                  pos_ff[0] <= req_tdata[COORD_BITS-1:0];
                  pos_ff[1] <= req_tdata[2*COORD_BITS-1:COORD_BITS];
                  pos_ff[2] <= req_tdata[3*COORD_BITS-1:2*COORD_BITS];
                  side_ff   <= side_eff;
                  axis_ff   <= 2'd0;
                  bit_ff    <= '0;
                  oor_ff    <= 1'b0;
                  sweep_ff  <= '0;
                  run_ff    <= '0;
                  if (req_tuser == KIND_COUNT || req_tuser == KIND_PLACE) begin
                     state_ff <= ST_DIV;
                  end else if (req_tuser == KIND_CLOSE && placing_ff) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_SWEEP;
                  end
               end
            end
            ST_DIV: begin
               if (bit_ff == '0) begin
                  num_ff <= PROD_BITS'(cur_pos) * PROD_BITS'(side_ff);
                  rem_ff <= '0;
                  quo_ff <= '0;
                  bit_ff <= bit_ff + 1'b1;
               end else begin
                  num_ff <= {num_ff[PROD_BITS-2:0], 1'b0};
                  if (trial >= box_ext) begin
                     rem_ff <= trial - box_ext;
                     quo_ff <= {quo_ff[AXIS_BITS-2:0], 1'b1};
                  end else begin
                     rem_ff <= trial;
                     quo_ff <= {quo_ff[AXIS_BITS-2:0], 1'b0};
                  end
                  if (bit_ff == ($clog2(PROD_BITS+1))'(PROD_BITS + 1)) begin
                     if (cur_pos >= box_ff) begin
                        ax_cell_ff[axis_ff] <= AXIS_BITS'(side_ff - 1'b1);
                        oor_ff <= 1'b1;
                     end else begin
                        ax_cell_ff[axis_ff] <= quo_ff;
                     end
                     bit_ff <= '0;
                     if (axis_ff == 2'd2) state_ff <= ST_READ;
                     else axis_ff <= axis_ff + 1'b1;
                  end else begin
                     bit_ff <= bit_ff + 1'b1;
                  end
               end
            end
            ST_READ: begin
               cell_ff  <= lin_cell;
               state_ff <= ST_MODIFY;   // address presented next cycle
            end
            ST_MODIFY: begin
               if (bit_ff == '0) begin
                  bit_ff <= bit_ff + 1'b1;   // memory read in flight
               end else begin
                  ovf  = 1'b0;
                  word = '0;
                  word[11:0] = 12'(cell_ff);
                  if (kind_ff == KIND_COUNT && !placing_ff) begin
                     ovf = (cnt_rd == COUNT_MAX) || (total_ff == COUNT_MAX);
                     word[27:12] = 16'((cnt_rd == COUNT_MAX) ? cnt_rd
                                                             : cnt_rd + 1'b1);
                     word[59:44] = 16'((total_ff == COUNT_MAX) ? total_ff
                                                               : total_ff + 1'b1);
                     if (total_ff != COUNT_MAX) total_ff <= total_ff + 1'b1;
                  end else if (kind_ff == KIND_PLACE && placing_ff) begin
                     sum = {1'b0, st_rd} + {1'b0, cnt_rd};
                     ovf = sum[COUNT_BITS] || (cnt_rd == COUNT_MAX);
                     word[27:12] = 16'(cnt_rd);
                     word[43:28] = 16'(sum[COUNT_BITS] ? COUNT_MAX
                                                       : sum[COUNT_BITS-1:0]);
                     word[59:44] = 16'(total_ff);
                  end else begin
                     word[59:44] = 16'(total_ff);
                  end
                  word[60] = oor_ff;
                  word[61] = ovf;
                  rsp_data_ff  <= word;
                  rsp_valid_ff <= 1'b1;
                  bit_ff   <= '0;
                  state_ff <= ST_IDLE;
               end
            end
            ST_SWEEP: begin
               if (sweep_ff != '0 && kind_ff == KIND_CLOSE) begin
                  sum = {1'b0, run_ff} + {1'b0, cnt_rd};
                  run_ff <= sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
               end
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == (CELL_BITS+1)'(NUM_CELLS)) begin
                  if (kind_ff == KIND_CLOSE) begin
                     placing_ff <= 1'b1;
                  end else begin
                     placing_ff <= 1'b0;
                     total_ff   <= '0;
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               word = '0;
               word[59:44] = 16'(total_ff);
               rsp_data_ff  <= word;
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != ST_IDLE)
      else $error("word accepted but block stayed idle");
   a_ready_only_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_valid_ff)
      else $error("ready while result pending");
   a_wipe_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WIPE |-> !req_tready && !rsp_valid_ff)
      else $error("activity during clearing pass");
`endif
endmodule
